/* rtl/core/hgp_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hgp_pkg
// Shared types and constants of the GET request header parser.
// ---------------------------------------------------------------------------
package hgp_pkg;

  localparam int MAX_W = 20;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam logic [9:0] VERSION_LIMIT = 10'd999;

  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_METHOD   = 4'd1;
  localparam logic [3:0] ERR_URL      = 4'd2;
  localparam logic [3:0] ERR_CONSTANT = 4'd3;
  localparam logic [3:0] ERR_VERSION  = 4'd4;
  localparam logic [3:0] ERR_LF       = 4'd5;
  localparam logic [3:0] ERR_TOKEN    = 4'd6;
  localparam logic [3:0] ERR_OVERFLOW = 4'd7;
  localparam logic [3:0] ERR_EOF      = 4'd8;

  localparam logic [1:0] ROLE_OTHER = 2'd0;
  localparam logic [1:0] ROLE_PATH  = 2'd1;
  localparam logic [1:0] ROLE_NAME  = 2'd2;
  localparam logic [1:0] ROLE_VALUE = 2'd3;

  // classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       is_digit;
    logic       is_token;
    logic       is_blank;
    logic       path_ok;
  } hgp_item_t;

  typedef struct packed {
    logic [1:0] byte_role;
    logic       path_done;
    logic       name_done;
    logic       value_done;
    logic       headers_done;
    logic       message_done;
    logic [3:0] error_code;
    logic [9:0] version_major;
    logic [9:0] version_minor;
  } hgp_result_t;

endpackage
`default_nettype wire

/* rtl/core/hgp_fifo.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hgp_fifo
// Small register queue with count-based full/empty.
// ---------------------------------------------------------------------------
module hgp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/hgp_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hgp_front
// Accepts raw bytes, tags character classes, queues them for the parser.
// ---------------------------------------------------------------------------
module hgp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_input,
  output logic                   full,
  input  wire logic              pop,
  output hgp_pkg::hgp_item_t     item,
  output logic                   empty
);
  import hgp_pkg::*;

  hgp_item_t cls;
  logic      alnum, punct;
  logic [7:0] c;

  assign c = data_byte;

  always_comb begin
    alnum = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    punct = (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                       8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E});
    cls          = '0;
    cls.data     = c;
    cls.eoi      = end_of_input;
    cls.is_digit = (c inside {[8'h30:8'h39]});
    cls.is_token = alnum || punct;
    cls.is_blank = (c == CH_SP) || (c == CH_HT);
    cls.path_ok  = (c inside {[8'h21:8'h7E]}) && (c != CH_HASH);
  end

  hgp_fifo #(.WIDTH($bits(hgp_item_t)), .DEPTH(2)) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (pop),
    .rdata (item),
    .empty (empty)
  );
endmodule
`default_nettype wire

/* rtl/core/hgp_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hgp_back
// Request-line and header state machine, one classified byte per cycle while go is high.
// ---------------------------------------------------------------------------
module hgp_back #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [hgp_pkg::MAX_W-1:0] max_header_bytes,
  input  wire logic                      go,
  input  wire hgp_pkg::hgp_item_t        item,
  output hgp_pkg::hgp_result_t           res
);
  import hgp_pkg::*;

  localparam int CMP_W = (COUNT_BITS > MAX_W) ? COUNT_BITS : MAX_W;

  typedef enum logic [4:0] {
    S_START, S_METHOD, S_SPACES_URL, S_PATH, S_HTTP_START, S_H, S_HT, S_HTT,
    S_HTTP, S_FIRST_MAJOR, S_MAJOR, S_FIRST_MINOR, S_MINOR, S_LINE_ALMOST,
    S_FIELD_START, S_FIELD, S_VALUE_START, S_VALUE, S_HEADER_ALMOST,
    S_VALUE_LWS, S_EMPTY_CR, S_EMPTY_LWS, S_HEADERS_ALMOST
  } state_t;

  state_t                state_r, state_nxt, ls_state;
  logic [1:0]            mpos_r, mpos_nxt;
  logic [9:0]            major_r, major_nxt, minor_r, minor_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [3:0]            err_r, err, ls_err;
  logic [1:0]            role, ls_role;
  logic                  p_path, p_name, p_value, fin, ls_fin;
  logic [7:0]            c;
  logic [13:0]           v_major, v_minor;

  assign c       = item.data;
  assign cnt_inc = (cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;
  assign v_major = 14'(major_r) * 14'd10 + 14'(c[3:0]);
  assign v_minor = 14'(minor_r) * 14'd10 + 14'(c[3:0]);

  // start of a header line (shared by several states)
  always_comb begin
    ls_state = state_r;
    ls_role  = ROLE_OTHER;
    ls_fin   = 1'b0;
    ls_err   = ERR_OK;
    if (c == CH_CR) begin
      ls_state = S_HEADERS_ALMOST;
    end else if (c == CH_LF) begin
      ls_fin = 1'b1;
    end else if (!item.is_token) begin
      ls_err = ERR_TOKEN;
    end else begin
      ls_role  = ROLE_NAME;
      ls_state = S_FIELD;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mpos_nxt  = mpos_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    cnt_nxt   = cnt_r;
    err       = ERR_OK;
    role      = ROLE_OTHER;
    p_path    = 1'b0;
    p_name    = 1'b0;
    p_value   = 1'b0;
    fin       = 1'b0;
    if (err_r == ERR_OK) begin
      if (item.eoi) begin
        if (state_r != S_START) err = ERR_EOF;
      end else begin
        cnt_nxt = cnt_inc;
        if (CMP_W'(cnt_inc) > CMP_W'(max_header_bytes)) begin
          err = ERR_OVERFLOW;
        end else begin
          case (state_r)
            S_METHOD: begin
              if (c == CH_SP && mpos_r == 2'd3) state_nxt = S_SPACES_URL;
              else if (mpos_r == 2'd1 && c == CH_E) mpos_nxt = 2'd2;
              else if (mpos_r == 2'd2 && c == CH_T) mpos_nxt = 2'd3;
              else err = ERR_METHOD;
            end
            S_SPACES_URL: begin
              if (c == CH_SP) begin
              end else if (c != CH_SLASH) begin
                err = ERR_URL;
              end else begin
                role      = ROLE_PATH;
                state_nxt = S_PATH;
              end
            end
            S_PATH: begin
              if (c == CH_SP) begin
                p_path    = 1'b1;
                state_nxt = S_HTTP_START;
              end else if (c == CH_CR || c == CH_LF) begin
                p_path    = 1'b1;
                major_nxt = 10'd0;
                minor_nxt = 10'd9;
                state_nxt = (c == CH_CR) ? S_LINE_ALMOST : S_FIELD_START;
              end else if (!item.path_ok) begin
                err = ERR_URL;
              end else begin
                role = ROLE_PATH;
              end
            end
            S_HTTP_START: begin
              if (c == CH_SP) begin
              end else if (c == CH_H) state_nxt = S_H;
              else err = ERR_CONSTANT;
            end
            S_H:    if (c == CH_T) state_nxt = S_HT; else err = ERR_CONSTANT;
            S_HT:   if (c == CH_T) state_nxt = S_HTT; else err = ERR_CONSTANT;
            S_HTT:  if (c == CH_P) state_nxt = S_HTTP; else err = ERR_CONSTANT;
            S_HTTP: begin
              if (c == CH_SLASH) state_nxt = S_FIRST_MAJOR;
              else err = ERR_CONSTANT;
            end
            S_FIRST_MAJOR: begin
              if (!item.is_digit || c[3:0] == 4'd0) begin
                err = ERR_VERSION;
              end else begin
                major_nxt = 10'(c[3:0]);
                state_nxt = S_MAJOR;
              end
            end
            S_MAJOR: begin
              if (c == CH_DOT) state_nxt = S_FIRST_MINOR;
              else if (!item.is_digit || v_major > 14'(VERSION_LIMIT)) err = ERR_VERSION;
              else major_nxt = v_major[9:0];
            end
            S_FIRST_MINOR: begin
              if (!item.is_digit) begin
                err = ERR_VERSION;
              end else begin
                minor_nxt = 10'(c[3:0]);
                state_nxt = S_MINOR;
              end
            end
            S_MINOR: begin
              if (c == CH_CR) state_nxt = S_LINE_ALMOST;
              else if (c == CH_LF) state_nxt = S_FIELD_START;
              else if (!item.is_digit || v_minor > 14'(VERSION_LIMIT)) err = ERR_VERSION;
              else minor_nxt = v_minor[9:0];
            end
            S_LINE_ALMOST: begin
              if (c != CH_LF) err = ERR_LF;
              else state_nxt = S_FIELD_START;
            end
            S_FIELD_START: begin
              state_nxt = ls_state;
              role      = ls_role;
              fin       = ls_fin;
              err       = ls_err;
            end
            S_FIELD: begin
              if (c == CH_COLON) begin
                p_name    = 1'b1;
                state_nxt = S_VALUE_START;
              end else if (!item.is_token) begin
                err = ERR_TOKEN;
              end else begin
                role = ROLE_NAME;
              end
            end
            S_VALUE_START: begin
              if (item.is_blank) begin
              end else if (c == CH_CR) state_nxt = S_EMPTY_CR;
              else if (c == CH_LF) state_nxt = S_EMPTY_LWS;
              else begin
                role      = ROLE_VALUE;
                state_nxt = S_VALUE;
              end
            end
            S_VALUE: begin
              if (c == CH_CR) begin
                p_value   = 1'b1;
                state_nxt = S_HEADER_ALMOST;
              end else if (c == CH_LF) begin
                p_value   = 1'b1;
                state_nxt = S_VALUE_LWS;
              end else begin
                role = ROLE_VALUE;
              end
            end
            S_HEADER_ALMOST: begin
              if (c != CH_LF) err = ERR_LF;
              else state_nxt = S_VALUE_LWS;
            end
            S_VALUE_LWS: begin
              if (item.is_blank) begin
                state_nxt = S_VALUE_START;
              end else begin
                state_nxt = ls_state;
                role      = ls_role;
                fin       = ls_fin;
                err       = ls_err;
              end
            end
            S_EMPTY_CR: begin
              if (c != CH_LF) err = ERR_LF;
              else state_nxt = S_EMPTY_LWS;
            end
            S_EMPTY_LWS: begin
              if (item.is_blank) begin
                state_nxt = S_VALUE_START;
              end else begin
                p_value   = 1'b1;
                state_nxt = ls_state;
                role      = ls_role;
                fin       = ls_fin;
                err       = ls_err;
              end
            end
            S_HEADERS_ALMOST: begin
              if (c != CH_LF) err = ERR_LF;
              else fin = 1'b1;
            end
            default: begin
              if (c == CH_CR || c == CH_LF) begin
                state_nxt = S_START;
              end else if (c != CH_G) begin
                err = ERR_METHOD;
              end else begin
                mpos_nxt  = 2'd1;
                state_nxt = S_METHOD;
              end
            end
          endcase
          if (fin) begin
            state_nxt = S_START;
            mpos_nxt  = 2'd0;
            cnt_nxt   = '0;
          end
        end
      end
      if (err != ERR_OK) begin
        state_nxt = state_r;
        mpos_nxt  = mpos_r;
        major_nxt = major_r;
        minor_nxt = minor_r;
        role      = ROLE_OTHER;
        p_path    = 1'b0;
        p_name    = 1'b0;
        p_value   = 1'b0;
        fin       = 1'b0;
      end
    end
  end

  always_comb begin
    res               = '0;
    res.byte_role     = role;
    res.path_done     = p_path;
    res.name_done     = p_name;
    res.value_done    = p_value;
    res.headers_done  = fin;
    res.message_done  = fin;
    res.error_code    = (err_r == ERR_OK) ? err : err_r;
    res.version_major = major_nxt;
    res.version_minor = minor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
      mpos_r  <= '0;
      major_r <= '0;
      minor_r <= '0;
      cnt_r   <= '0;
      err_r   <= ERR_OK;
    end else if (go) begin
      state_r <= state_nxt;
      mpos_r  <= mpos_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      cnt_r   <= cnt_nxt;
      if (err_r == ERR_OK) err_r <= err;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/http_get_request_header_parser.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// http_get_request_header_parser
// Byte-stream parser for an HTTP GET request line and header block.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in_*      input      in_push / in_full         data_byte, end_of_input
// out_*     output     out_pop / out_empty       role, span pulses, error, version
// APB       config     psel/penable/pwrite       max_header_bytes at byte 0x0
//
// One result transaction per input transaction; sustained one byte per clock
// while the output queue has room. A byte passes the input queue, then the
// parser into the output queue; the parser state machine loop sets the rate.
// Synchronous active-low reset empties both queues and returns to request start.
// A full output queue stalls the parser; the input queue keeps taking bytes
// until it too is full.
// ---------------------------------------------------------------------------
module http_get_request_header_parser #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_input,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_byte_role,
  output logic             out_path_done,
  output logic             out_name_done,
  output logic             out_value_done,
  output logic             out_headers_done,
  output logic             out_message_done,
  output logic [3:0]       out_error_code,
  output logic [9:0]       out_version_major,
  output logic [9:0]       out_version_minor,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import hgp_pkg::*;

  logic [MAX_W-1:0] max_r;
  hgp_item_t        item;
  hgp_result_t      res, res_q;
  logic             q_empty, o_full, go;

  // config: single register at byte 0x0
  assign pready = 1'b1;
  assign prdata = {{(32 - MAX_W){1'b0}}, max_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_W'(81920);
    end else if (psel && penable && pwrite && (paddr == 2'b00)) begin
      max_r <= pwdata[MAX_W-1:0];
    end
  end

  hgp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .data_byte    (in_data_byte),
    .end_of_input (in_end_of_input),
    .full         (in_full),
    .pop          (go),
    .item         (item),
    .empty        (q_empty)
  );

  // parser advances only when a byte waits and the result has room
  assign go = !q_empty && !o_full;

  hgp_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .max_header_bytes (max_r),
    .go               (go),
    .item             (item),
    .res              (res)
  );

  hgp_fifo #(.WIDTH($bits(hgp_result_t)), .DEPTH(2)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (go),
    .wdata (res),
    .full  (o_full),
    .pop   (out_pop),
    .rdata (res_q),
    .empty (out_empty)
  );

  assign out_byte_role     = res_q.byte_role;
  assign out_path_done     = res_q.path_done;
  assign out_name_done     = res_q.name_done;
  assign out_value_done    = res_q.value_done;
  assign out_headers_done  = res_q.headers_done;
  assign out_message_done  = res_q.message_done;
  assign out_error_code    = res_q.error_code;
  assign out_version_major = res_q.version_major;
  assign out_version_minor = res_q.version_minor;
endmodule
`default_nettype wire

/* rtl/core/hgp_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hgp_checker
// Port-level checks of the GET request header parser.
// ---------------------------------------------------------------------------
module hgp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [1:0]  out_byte_role,
  input wire logic        out_path_done,
  input wire logic        out_name_done,
  input wire logic        out_value_done,
  input wire logic        out_headers_done,
  input wire logic        out_message_done,
  input wire logic [3:0]  out_error_code
);
  // nothing buffered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // error code is sticky across result transactions
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_error_code != 4'd0) |=>
      (out_empty || out_error_code == $past(out_error_code)))
    else $error("error code cleared");

  // an errored result carries no role and no pulses
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_error_code != 4'd0) |->
      (out_byte_role == 2'd0 && !out_path_done && !out_name_done &&
       !out_value_done && !out_headers_done))
    else $error("errored result not quiet");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_byte_role) &&
      $stable(out_error_code) && $stable(out_message_done)))
    else $error("stalled result changed");

  // end of headers and end of message pulse together
  a_done_pair: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_message_done == out_headers_done))
    else $error("done pulses differ");
endmodule

bind http_get_request_header_parser hgp_checker u_hgp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_byte_role    (out_byte_role),
  .out_path_done    (out_path_done),
  .out_name_done    (out_name_done),
  .out_value_done   (out_value_done),
  .out_headers_done (out_headers_done),
  .out_message_done (out_message_done),
  .out_error_code   (out_error_code)
);
`default_nettype wire

/* test/testbench.sv */
// ---------------------------------------------------------------------------
// GET request header parser testbench
// Drives byte streams of well-formed GET requests with random content, plus
// directed corner cases, through the queue-style input. Every result
// transaction is checked field by field against an in-bench parser model.
// The run ends in one sticky error of a randomly chosen kind, followed by
// noise that must leave the error in place.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hgp_pkg::*;

  localparam int IDLE_LIMIT = 2000;   // cycles without any transaction

  // parser states of the bench model
  typedef enum logic [4:0] {
    P_START, P_METHOD, P_URL_SP, P_PATH, P_VER_SP, P_H, P_HT, P_HTT, P_HTTP,
    P_MAJ0, P_MAJ, P_MIN0, P_MIN, P_LINE_CR, P_FLD_START, P_FLD, P_VAL_START,
    P_VAL, P_HDR_CR, P_VAL_LWS, P_EMPTY_CR, P_EMPTY_LWS, P_END_CR
  } pstate_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_data_byte;
  logic        in_end_of_input;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_byte_role;
  logic        out_path_done;
  logic        out_name_done;
  logic        out_value_done;
  logic        out_headers_done;
  logic        out_message_done;
  logic [3:0]  out_error_code;
  logic [9:0]  out_version_major;
  logic [9:0]  out_version_minor;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  http_get_request_header_parser DUT (.*);

  // model state
  pstate_t     m_state;
  logic [1:0]  m_mpos;
  logic [9:0]  m_major;
  logic [9:0]  m_minor;
  logic [19:0] m_count;
  logic [3:0]  m_err;
  logic [19:0] m_limit;
  hgp_result_t m_out;             // tags being built for the current byte

  hgp_result_t byte_tags_due[$];  // expected result transactions, oldest first
  int          fail_count;
  int          bytes_sent;
  int          idle_cycles;
  logic        steady_in;         // no gaps on the input side for a while
  logic        steady_out;        // no stalls on the result side for a while

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- bench model --------------------------------------------------------

  function automatic logic is_tok(input logic [7:0] c);
    if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
      return 1'b1;
    case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2E,
      8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_HT;
  endfunction

  function automatic void close_message();
    m_out.headers_done = 1'b1;
    m_out.message_done = 1'b1;
    m_state = P_START;
    m_mpos = 2'd0;
    m_count = '0;
  endfunction

  function automatic logic [3:0] begin_line(input logic [7:0] c);
    if (c == CH_CR) begin
      m_state = P_END_CR;
      return ERR_OK;
    end
    if (c == CH_LF) begin
      close_message();
      return ERR_OK;
    end
    if (!is_tok(c)) return ERR_TOKEN;
    m_out.byte_role = ROLE_NAME;
    m_state = P_FLD;
    return ERR_OK;
  endfunction

  // accumulate one version digit; returns the error, leaves acc on overflow
  function automatic logic [3:0] add_digit(inout logic [9:0] acc, input logic [7:0] c);
    int v;
    if (c < "0" || c > "9") return ERR_VERSION;
    v = acc * 10 + (c - "0");
    if (v > VERSION_LIMIT) return ERR_VERSION;
    acc = v[9:0];
    return ERR_OK;
  endfunction

  function automatic logic [3:0] match_char(input logic [7:0] c, input logic [7:0] want,
                                             input pstate_t nxt);
    if (c != want) return ERR_CONSTANT;
    m_state = nxt;
    return ERR_OK;
  endfunction

  function automatic logic [3:0] parse_char(input logic [7:0] c);
    case (m_state)
      P_METHOD: begin
        if (c == CH_SP && m_mpos == 2'd3) begin
          m_state = P_URL_SP;
          return ERR_OK;
        end
        if (m_mpos == 2'd1 && c == CH_E) begin
          m_mpos = 2'd2;
          return ERR_OK;
        end
        if (m_mpos == 2'd2 && c == CH_T) begin
          m_mpos = 2'd3;
          return ERR_OK;
        end
        return ERR_METHOD;
      end
      P_URL_SP: begin
        if (c == CH_SP) return ERR_OK;
        if (c != CH_SLASH) return ERR_URL;
        m_out.byte_role = ROLE_PATH;
        m_state = P_PATH;
        return ERR_OK;
      end
      P_PATH: begin
        if (c == CH_SP) begin
          m_out.path_done = 1'b1;
          m_state = P_VER_SP;
          return ERR_OK;
        end
        if (c == CH_CR || c == CH_LF) begin
          // no version on the line: HTTP/0.9
          m_out.path_done = 1'b1;
          m_major = 10'd0;
          m_minor = 10'd9;
          m_state = (c == CH_CR) ? P_LINE_CR : P_FLD_START;
          return ERR_OK;
        end
        if (c < 8'h21 || c > 8'h7E || c == CH_HASH) return ERR_URL;
        m_out.byte_role = ROLE_PATH;
        return ERR_OK;
      end
      P_VER_SP: begin
        if (c == CH_SP) return ERR_OK;
        return match_char(c, CH_H, P_H);
      end
      P_H:    return match_char(c, CH_T, P_HT);
      P_HT:   return match_char(c, CH_T, P_HTT);
      P_HTT:  return match_char(c, CH_P, P_HTTP);
      P_HTTP: return match_char(c, CH_SLASH, P_MAJ0);
      P_MAJ0: begin
        if (c < "1" || c > "9") return ERR_VERSION;
        m_major = c - "0";
        m_state = P_MAJ;
        return ERR_OK;
      end
      P_MAJ: begin
        if (c == CH_DOT) begin
          m_state = P_MIN0;
          return ERR_OK;
        end
        return add_digit(m_major, c);
      end
      P_MIN0: begin
        if (c < "0" || c > "9") return ERR_VERSION;
        m_minor = c - "0";
        m_state = P_MIN;
        return ERR_OK;
      end
      P_MIN: begin
        if (c == CH_CR) begin
          m_state = P_LINE_CR;
          return ERR_OK;
        end
        if (c == CH_LF) begin
          m_state = P_FLD_START;
          return ERR_OK;
        end
        return add_digit(m_minor, c);
      end
      P_LINE_CR: begin
        if (c != CH_LF) return ERR_LF;
        m_state = P_FLD_START;
        return ERR_OK;
      end
      P_FLD_START: return begin_line(c);
      P_FLD: begin
        if (c == CH_COLON) begin
          m_out.name_done = 1'b1;
          m_state = P_VAL_START;
          return ERR_OK;
        end
        if (!is_tok(c)) return ERR_TOKEN;
        m_out.byte_role = ROLE_NAME;
        return ERR_OK;
      end
      P_VAL_START: begin
        if (is_blank(c)) return ERR_OK;
        if (c == CH_CR) begin
          m_state = P_EMPTY_CR;
          return ERR_OK;
        end
        if (c == CH_LF) begin
          m_state = P_EMPTY_LWS;
          return ERR_OK;
        end
        m_out.byte_role = ROLE_VALUE;
        m_state = P_VAL;
        return ERR_OK;
      end
      P_VAL: begin
        if (c == CH_CR || c == CH_LF) begin
          m_out.value_done = 1'b1;
          m_state = (c == CH_CR) ? P_HDR_CR : P_VAL_LWS;
          return ERR_OK;
        end
        m_out.byte_role = ROLE_VALUE;
        return ERR_OK;
      end
      P_HDR_CR: begin
        if (c != CH_LF) return ERR_LF;
        m_state = P_VAL_LWS;
        return ERR_OK;
      end
      P_VAL_LWS: begin
        if (is_blank(c)) begin
          m_state = P_VAL_START;
          return ERR_OK;
        end
        return begin_line(c);
      end
      P_EMPTY_CR: begin
        if (c != CH_LF) return ERR_LF;
        m_state = P_EMPTY_LWS;
        return ERR_OK;
      end
      P_EMPTY_LWS: begin
        if (is_blank(c)) begin
          m_state = P_VAL_START;
          return ERR_OK;
        end
        // empty value ends on the first byte of the next line
        m_out.value_done = 1'b1;
        return begin_line(c);
      end
      P_END_CR: begin
        if (c != CH_LF) return ERR_LF;
        close_message();
        return ERR_OK;
      end
      default: begin
        // request start: blank lines skipped
        if (c == CH_CR || c == CH_LF) begin
          m_state = P_START;
          return ERR_OK;
        end
        if (c != CH_G) return ERR_METHOD;
        m_mpos = 2'd1;
        m_state = P_METHOD;
        return ERR_OK;
      end
    endcase
  endfunction

  function automatic hgp_result_t tag_byte(input logic [7:0] c, input logic eoi);
    logic [3:0] e;
    m_out = '0;
    if (m_err == ERR_OK) begin
      e = ERR_OK;
      if (eoi) begin
        if (m_state != P_START) e = ERR_EOF;
      end else begin
        if (m_count != '1) m_count = m_count + 1'b1;   // saturating
        if (m_count > m_limit) e = ERR_OVERFLOW;
        else e = parse_char(c);
      end
      if (e != ERR_OK) begin
        m_err = e;
        m_out = '0;
      end
    end
    m_out.error_code = m_err;
    m_out.version_major = m_major;
    m_out.version_minor = m_minor;
    return m_out;
  endfunction

  // ---- result side --------------------------------------------------------

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    int w;
    hgp_result_t due;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      w = steady_out ? 0 : $urandom_range(0, 17);
      if (w != 0) begin
        out_pop <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      if (byte_tags_due.size() == 0) begin
        $error("result transaction with no byte waiting for it");
        fail_count++;
      end else begin
        due = byte_tags_due.pop_front();
        check_field("byte_role", due.byte_role, out_byte_role);
        check_field("path_done", due.path_done, out_path_done);
        check_field("name_done", due.name_done, out_name_done);
        check_field("value_done", due.value_done, out_value_done);
        check_field("headers_done", due.headers_done, out_headers_done);
        check_field("message_done", due.message_done, out_message_done);
        check_field("error_code", due.error_code, out_error_code);
        check_field("version_major", due.version_major, out_version_major);
        check_field("version_minor", due.version_minor, out_version_minor);
      end
      @(negedge clk);
    end
  end

  // watchdog: any transaction on either channel or the config port resets it
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || psel)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // ---- input side ---------------------------------------------------------

  // Send one byte transaction; starts and ends on a falling edge. in_push is
  // left high so back-to-back bytes are sent without a gap.
  task automatic push_byte(input logic [7:0] c, input logic eoi);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= c;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_full);
    byte_tags_due.push_back(tag_byte(c, eoi));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  // stop sending and let every pending result drain
  task automatic go_idle();
    in_push <= 1'b0;
    wait (byte_tags_due.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  // write max_header_bytes, then read it back
  task automatic set_limit(input logic [19:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= {12'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    m_limit = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("max_header_bytes", v, prdata[19:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] rand_tok();
    string tok_set;
    tok_set = "!#$%&'*+-.^_|~0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    if ($urandom_range(0, 39) == 0) return 8'h60;
    return tok_set[$urandom_range(0, tok_set.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_path_char();
    logic [7:0] c;
    do c = $urandom_range(8'h21, 8'h7E); while (c == CH_HASH);
    return c;
  endfunction

  // value bytes: anything but CR/LF; the first one also not a blank
  function automatic logic [7:0] rand_value_char(input logic first);
    logic [7:0] c;
    do c = $urandom_range(0, 255);
    while (c == CH_CR || c == CH_LF || (first && is_blank(c)));
    return c;
  endfunction

  task automatic push_eol();
    if ($urandom_range(0, 1)) push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b0);
  endtask

  task automatic push_value();
    int n;
    n = $urandom_range(0, 10);
    repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 1) ? CH_SP : CH_HT, 1'b0);
    for (int i = 0; i < n; i++) push_byte(rand_value_char(i == 0), 1'b0);
    push_eol();
  endtask

  // one well-formed request with random content (at most ~190 bytes)
  task automatic push_request();
    steady_in = ($urandom_range(0, 3) == 0);
    steady_out = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) push_byte($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
    push_text("GET");
    repeat ($urandom_range(1, 3)) push_byte(CH_SP, 1'b0);
    push_byte(CH_SLASH, 1'b0);
    repeat ($urandom_range(0, 12)) push_byte(rand_path_char(), 1'b0);
    if ($urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(1, 2)) push_byte(CH_SP, 1'b0);
      push_text("HTTP/");
      push_byte($urandom_range("1", "9"), 1'b0);
      repeat ($urandom_range(0, 2)) push_byte($urandom_range("0", "9"), 1'b0);
      push_byte(CH_DOT, 1'b0);
      repeat ($urandom_range(1, 3)) push_byte($urandom_range("0", "9"), 1'b0);
    end
    push_eol();
    repeat ($urandom_range(0, 4)) begin
      repeat ($urandom_range(1, 8)) push_byte(rand_tok(), 1'b0);
      push_byte(CH_COLON, 1'b0);
      push_value();
      if ($urandom_range(0, 3) == 0) begin
        push_byte($urandom_range(0, 1) ? CH_SP : CH_HT, 1'b0);
        push_value();
      end
    end
    push_eol();
    // end-of-input at request start is legal
    if ($urandom_range(0, 5) == 0) push_byte($urandom_range(0, 255), 1'b1);
  endtask

  // ---- tests --------------------------------------------------------------

  task automatic test_directed();
    // reset value reads back and is rewritten unchanged
    set_limit(20'd81920);
    push_byte(8'hFF, 1'b1);
    push_text("\015\nGET /!~ HTTP/999.999\015\n");
    push_text("A-z09!#$%&'*+.^_|~");
    push_byte(8'h60, 1'b0);
    push_text(":\t x\015\n \tcont\015\nE:\015\nF:\015\n\015\n");
    // HTTP/0.9 line, empty value continued on an indented line
    push_text("GET /a\nG:\n y\n\n");
    push_text("GET  / HTTP/1.0\n\n");
    go_idle();
  endtask

  // lowest limit: one blank line fits exactly, end-of-input is not counted
  task automatic test_limit_low();
    set_limit(20'd1);
    push_byte($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
    push_byte($urandom_range(0, 255), 1'b1);
    go_idle();
  endtask

  task automatic test_random(input logic [19:0] lim, input int n_bytes);
    int stop_at;
    set_limit(lim);
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) push_request();
    go_idle();
  endtask

  // one error of a random kind, then noise that must not clear it
  task automatic test_sticky_error();
    logic [3:0] kind;
    kind = $urandom_range(ERR_METHOD, ERR_EOF);
    steady_in = 1'b0;
    steady_out = 1'b0;
    case (kind)
      ERR_METHOD:   push_text("GX");
      ERR_URL:      push_text("GET x");
      ERR_CONSTANT: push_text("GET / HX");
      ERR_VERSION:  push_text($urandom_range(0, 1) ? "GET / HTTP/0" : "GET / HTTP/1.1000");
      ERR_LF:       push_text("GET /\015X");
      ERR_TOKEN:    push_text("GET /\n(");
      ERR_OVERFLOW: begin
        set_limit(20'd1);
        push_text("\n\n");
      end
      default: begin
        push_text("GET");
        push_byte($urandom_range(0, 255), 1'b1);
      end
    endcase
    repeat (40) push_byte($urandom_range(0, 255), $urandom_range(0, 7) == 0);
    go_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data_byte = 8'd0;
    in_end_of_input = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 2'd0;
    pwdata = 32'd0;
    fail_count = 0;
    bytes_sent = 0;
    steady_in = 1'b0;
    steady_out = 1'b0;
    m_state = P_START;
    m_mpos = 2'd0;
    m_major = 10'd0;
    m_minor = 10'd0;
    m_count = '0;
    m_err = ERR_OK;
    m_limit = 20'd81920;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_limit_low();
    test_random(20'd81920, 380);
    test_random(20'hFFFFF, 380);
    test_random(20'd256, 380);
    test_sticky_error();

    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
